/* rtl/rsq_pkg.sv */
// ----------------------------------------------------------------------------
// rsq_pkg
// Shared types and constants of the rotated sprite quad setup unit.
// ----------------------------------------------------------------------------
package rsq_pkg;

  localparam int ANGLE_BITS_DEF = 12;
  localparam int COORD_FRAC_DEF = 4;

  localparam logic [14:0] SIN_A   = 15'd25736;
  localparam logic [13:0] SIN_B   = 14'd10512;
  localparam logic [10:0] SIN_C   = 11'd1160;
  localparam logic [14:0] ONE_Q14 = 15'd16384;

  localparam logic [1:0]  CORNER_LAST = 2'd3;
  localparam logic [15:0] TEX_MAX     = 16'hFFFF;

  typedef struct packed {
    logic               anchor_mode;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [11:0]        rect_left;
    logic [11:0]        rect_top;
    logic [11:0]        rect_right;
    logic [11:0]        rect_bottom;
    logic [12:0]        tex_width;
    logic [12:0]        tex_height;
    logic [11:0]        rotation;
    logic [11:0]        scale_x;
    logic [11:0]        scale_y;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] vertex_x;
    logic signed [19:0] vertex_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [1:0]         corner_index;
    logic               last_corner;
  } out_item_t;

endpackage

/* rtl/rsq_in_if.sv */
// ----------------------------------------------------------------------------
// rsq_in_if
// Sprite descriptor channel: valid, ready and one sprite per beat.
// ----------------------------------------------------------------------------
interface rsq_in_if import rsq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rsq_out_if.sv */
// ----------------------------------------------------------------------------
// rsq_out_if
// Vertex channel: valid, ready and one corner vertex per beat.
// ----------------------------------------------------------------------------
interface rsq_out_if import rsq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rotated_sprite_quad_setup_unit.sv */
// ----------------------------------------------------------------------------
// rotated_sprite_quad_setup_unit
// Turns one sprite descriptor into four rotated, scaled corner vertices.
// ----------------------------------------------------------------------------
// A sprite beat passes a nine-stage pipeline (sine/cosine polynomial, extent
// products, corner sums, rounding with saturation, and a radix-4 texture
// divider in parallel) and lands in a vertex buffer that sends four beats,
// corners 0 to 3, with last_corner on the fourth. The vertex port sets the
// sustained rate; the buffer loads the next sprite as the last corner beat
// of the one before leaves. The pipeline takes a sprite in every cycle unless
// a sprite waits in its last stage, also while the buffer still sends.
module rotated_sprite_quad_setup_unit
  import rsq_pkg::*;
#(
  parameter int ANGLE_BITS          = ANGLE_BITS_DEF,
  parameter int COORD_FRACTION_BITS = COORD_FRAC_DEF
) (
  input logic     clk,
  input logic     rst_n,
  rsq_in_if.sink  in_bus,
  rsq_out_if.source out_bus
);

  localparam int NSTG      = 9;
  localparam int RND_SHIFT = 23 - COORD_FRACTION_BITS;
  localparam int PH_SHIFT  = 16 - ANGLE_BITS;
  localparam logic [15:0] ANG_MASK = 16'((32'd1 << ANGLE_BITS) - 32'd1);
  localparam logic signed [43:0] RND_HALF = 44'(64'sd1 <<< (RND_SHIFT - 1));

  in_item_t d;
  logic     en;
  logic     ser_free;
  logic     take;
  logic     out_fire;

  logic v_r [1:NSTG];

  logic [1:0]  sq_r  [1:4][0:1];
  logic [14:0] st_r  [1:4][0:1];
  logic [14:0] t2_r  [2:3][0:1];
  logic [13:0] inner_r [0:1];
  logic [14:0] mid_r [0:1];
  logic signed [16:0] trig_r [0:1];

  logic [23:0] ext_r [1:5][0:1];
  logic        centre_r [1:6];
  logic signed [15:0] ox_r [1:7];
  logic signed [15:0] oy_r [1:7];

  logic signed [41:0] prod_r [0:3];
  logic signed [43:0] rx_r [0:3];
  logic signed [43:0] ry_r [0:3];
  logic signed [31:0] px_r [0:3];
  logic signed [31:0] py_r [0:3];
  logic signed [19:0] vx_r [0:3];
  logic signed [19:0] vy_r [0:3];

  logic [25:0] dv_rem_r [1:8][0:3];
  logic [12:0] dv_d_r   [1:8][0:3];
  logic [15:0] dv_q_r   [1:9][0:3];
  logic        dv_sat_r [1:9][0:3];

  logic [25:0] dv_rem_nxt [2:9][0:3];
  logic [15:0] dv_q_nxt   [2:9][0:3];

  logic [15:0] phase_nxt;
  logic [1:0]  sq_nxt [0:1];
  logic [14:0] st_nxt [0:1];
  logic [23:0] ext_nxt [0:1];
  logic [25:0] num_nxt [0:3];
  logic [12:0] den_nxt [0:3];
  logic        sat_nxt [0:3];

  logic signed [19:0] h_vx_r [0:3];
  logic signed [19:0] h_vy_r [0:3];
  logic [15:0] h_u_r [0:1];
  logic [15:0] h_v_r [0:1];
  logic [1:0]  cnt_r;
  logic        hold_v_r;

  function automatic logic signed [43:0] cterm(logic signed [41:0] p, logic ctr, logic pos);
    logic signed [43:0] e;
    e = 44'(p);
    if (ctr) begin
      return pos ? e : -e;
    end
    return pos ? (e <<< 1) : '0;
  endfunction

  function automatic logic signed [19:0] sat20(logic signed [31:0] v);
    if (v > 32'sd524287) begin
      return 20'sd524287;
    end
    if (v < -32'sd524288) begin
      return -20'sd524288;
    end
    return 20'(v);
  endfunction

  assign d        = in_bus.data;
  assign out_fire = out_bus.valid && out_bus.ready;
  assign ser_free = !hold_v_r || (out_fire && cnt_r == CORNER_LAST);
  assign take     = v_r[NSTG] && ser_free;
  assign en       = !v_r[NSTG] || ser_free;
  assign in_bus.ready = en;

  // stage 1 operands
  always_comb begin
    logic [15:0] p;
    logic [11:0] w;
    logic [11:0] h;
    logic [12:0] sz;
    logic [11:0] edg;
    phase_nxt = (16'(d.rotation) & ANG_MASK) << PH_SHIFT;
    for (int c = 0; c < 2; c++) begin
      p = (c == 1) ? phase_nxt + 16'(ONE_Q14) : phase_nxt;
      sq_nxt[c] = p[15:14];
      st_nxt[c] = p[14] ? ONE_Q14 - {1'b0, p[13:0]} : {1'b0, p[13:0]};
    end
    w = (d.rect_right >= d.rect_left) ? d.rect_right - d.rect_left
                                      : d.rect_left - d.rect_right;
    h = (d.rect_bottom >= d.rect_top) ? d.rect_bottom - d.rect_top
                                      : d.rect_top - d.rect_bottom;
    ext_nxt[0] = w * d.scale_x;
    ext_nxt[1] = h * d.scale_y;
    for (int c = 0; c < 4; c++) begin
      sz  = (c < 2) ? d.tex_width : d.tex_height;
      case (c)
        0:       edg = d.rect_left;
        1:       edg = d.rect_right;
        2:       edg = d.rect_top;
        default: edg = d.rect_bottom;
      endcase
      num_nxt[c] = {edg, 14'd0} + 26'(sz >> 1);
      den_nxt[c] = sz;
      sat_nxt[c] = (sz == 13'd0) || ({3'd0, num_nxt[c]} >= {sz, 16'd0});
    end
  end

  // divider: two quotient bits per stage
  always_comb begin
    logic [25:0] rem;
    logic [15:0] qv;
    logic [28:0] dsh;
    int          i;
    for (int j = 2; j <= NSTG; j++) begin
      for (int c = 0; c < 4; c++) begin
        rem = dv_rem_r[j-1][c];
        qv  = dv_q_r[j-1][c];
        for (int s = 0; s < 2; s++) begin
          i   = 15 - 2 * (j - 2) - s;
          dsh = 29'(dv_d_r[j-1][c]) << i;
          if ({3'd0, rem} >= dsh) begin
            rem   = rem - 26'(dsh);
            qv[i] = 1'b1;
          end
        end
        dv_rem_nxt[j][c] = rem;
        dv_q_nxt[j][c]   = qv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 1; j <= NSTG; j++) begin
        v_r[j] <= 1'b0;
      end
    end else if (en) begin
      v_r[1] <= in_bus.valid;
      for (int j = 2; j <= NSTG; j++) begin
        v_r[j] <= v_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      centre_r[1] <= d.anchor_mode;
      ox_r[1]     <= d.origin_x;
      oy_r[1]     <= d.origin_y;
      for (int j = 2; j <= 6; j++) begin
        centre_r[j] <= centre_r[j-1];
      end
      for (int j = 2; j <= 7; j++) begin
        ox_r[j] <= ox_r[j-1];
        oy_r[j] <= oy_r[j-1];
      end

      for (int c = 0; c < 2; c++) begin
        sq_r[1][c]  <= sq_nxt[c];
        st_r[1][c]  <= st_nxt[c];
        ext_r[1][c] <= ext_nxt[c];
        for (int j = 2; j <= 4; j++) begin
          sq_r[j][c] <= sq_r[j-1][c];
          st_r[j][c] <= st_r[j-1][c];
        end
        for (int j = 2; j <= 5; j++) begin
          ext_r[j][c] <= ext_r[j-1][c];
        end
        t2_r[2][c]  <= 15'((30'(st_r[1][c]) * 30'(st_r[1][c])) >> 14);
        t2_r[3][c]  <= t2_r[2][c];
        inner_r[c]  <= SIN_B - 14'((26'(t2_r[2][c]) * 26'(SIN_C)) >> 14);
        mid_r[c]    <= SIN_A - 15'((29'(t2_r[3][c]) * 29'(inner_r[c])) >> 14);
        trig_r[c]   <= sq_r[4][c][1]
                       ? -$signed({2'b00, 15'((30'(st_r[4][c]) * 30'(mid_r[c])) >> 14)})
                       :  $signed({2'b00, 15'((30'(st_r[4][c]) * 30'(mid_r[c])) >> 14)});
      end

      // trig_r[0] is sine, trig_r[1] is cosine
      prod_r[0] <= $signed({1'b0, ext_r[5][0]}) * trig_r[1];
      prod_r[1] <= $signed({1'b0, ext_r[5][0]}) * trig_r[0];
      prod_r[2] <= $signed({1'b0, ext_r[5][1]}) * trig_r[1];
      prod_r[3] <= $signed({1'b0, ext_r[5][1]}) * trig_r[0];

      for (int k = 0; k < 4; k++) begin
        rx_r[k] <= cterm(prod_r[0], centre_r[6], k == 1 || k == 2)
                 - cterm(prod_r[3], centre_r[6], k >= 2);
        ry_r[k] <= cterm(prod_r[1], centre_r[6], k == 1 || k == 2)
                 + cterm(prod_r[2], centre_r[6], k >= 2);
        px_r[k] <= 32'((rx_r[k] + RND_HALF) >>> RND_SHIFT) + 32'(ox_r[7]);
        py_r[k] <= 32'((ry_r[k] + RND_HALF) >>> RND_SHIFT) + 32'(oy_r[7]);
        vx_r[k] <= sat20(px_r[k]);
        vy_r[k] <= sat20(py_r[k]);
      end

      for (int c = 0; c < 4; c++) begin
        dv_rem_r[1][c] <= num_nxt[c];
        dv_d_r[1][c]   <= den_nxt[c];
        dv_q_r[1][c]   <= '0;
        dv_sat_r[1][c] <= sat_nxt[c];
        for (int j = 2; j <= NSTG; j++) begin
          dv_q_r[j][c]   <= dv_q_nxt[j][c];
          dv_sat_r[j][c] <= dv_sat_r[j-1][c];
        end
        for (int j = 2; j <= 8; j++) begin
          dv_rem_r[j][c] <= dv_rem_nxt[j][c];
          dv_d_r[j][c]   <= dv_d_r[j-1][c];
        end
      end
    end
  end

  // vertex buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      cnt_r    <= '0;
    end else if (take) begin
      hold_v_r <= 1'b1;
      cnt_r    <= '0;
    end else if (out_fire) begin
      if (cnt_r == CORNER_LAST) begin
        hold_v_r <= 1'b0;
      end
      cnt_r <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < 4; k++) begin
        h_vx_r[k] <= vx_r[k];
        h_vy_r[k] <= vy_r[k];
      end
      for (int c = 0; c < 2; c++) begin
        h_u_r[c] <= dv_sat_r[NSTG][c]     ? TEX_MAX : dv_q_r[NSTG][c];
        h_v_r[c] <= dv_sat_r[NSTG][c + 2] ? TEX_MAX : dv_q_r[NSTG][c + 2];
      end
    end
  end

  assign out_bus.valid             = hold_v_r;
  assign out_bus.data.vertex_x     = h_vx_r[cnt_r];
  assign out_bus.data.vertex_y     = h_vy_r[cnt_r];
  assign out_bus.data.tex_u        = h_u_r[cnt_r[0] ^ cnt_r[1]];
  assign out_bus.data.tex_v        = h_v_r[cnt_r[1]];
  assign out_bus.data.corner_index = cnt_r;
  assign out_bus.data.last_corner  = (cnt_r == CORNER_LAST);

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NSTG] && !ser_free |=> v_r[NSTG])
    else $error("stalled sprite dropped from last stage");

  a_buf_holds: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r && !out_fire |=> hold_v_r && $stable(cnt_r))
    else $error("vertex buffer moved without a beat");

  a_load_first: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> hold_v_r && cnt_r == 2'd0)
    else $error("new sprite not started at first corner");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && cnt_r == CORNER_LAST && !take |=> !hold_v_r)
    else $error("vertex buffer did not drain after last corner");

endmodule
